>>> src/arc_swipe_wake_detector_macros.svh
// Assertion macros for the arc swipe wake detector.
// Used by the port checker; needs nothing else.
`ifndef ARC_SWIPE_WAKE_DETECTOR_MACROS_SVH
`define ARC_SWIPE_WAKE_DETECTOR_MACROS_SVH

// clocked check, quiet while reset is high
`define ASW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define ASW_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/asw_pkg.sv
// Shared types, codes and helpers for the arc swipe wake detector.
// No dependencies.
package asw_pkg;

  localparam int COORD_WIDTH = 16;
  // wide signed width for comparing coordinates with unsigned settings
  localparam int WIDE_W = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;

  // event kinds
  localparam logic [2:0] KIND_X     = 3'd0;
  localparam logic [2:0] KIND_Y     = 3'd1;
  localparam logic [2:0] KIND_SLOT  = 3'd2;
  localparam logic [2:0] KIND_TRACK = 3'd3;
  localparam logic [2:0] KIND_KEY   = 3'd4;

  localparam logic [15:0] TRACK_LIFT = 16'hFFFF;
  localparam logic [15:0] KEY_UP     = 16'h0000;

  // enable modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ARC_CP = 2'd1;
  localparam logic [1:0] MODE_ARC    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_INNER    = 3'd3;
  localparam logic [2:0] REG_OUTER    = 3'd4;
  localparam logic [2:0] REG_SIDE_ROW = 3'd5;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RESET,
    OP_EVAL
  } op_t;

  typedef struct packed {
    op_t    op;
    coord_t x;
    coord_t y;
  } req_t;

  typedef struct packed {
    logic [1:0]  enable_mode;
    logic [13:0] center_x;
    logic [14:0] screen_height;
    logic [14:0] inner_radius;
    logic [14:0] outer_radius;
    logic [14:0] side_row;
  } cfg_t;

  // floor(n / 3) for n below 2^17, by reciprocal multiply
  function automatic logic [16:0] div3(input logic [16:0] n);
    logic [35:0] p;
    p = {19'b0, n} * 36'd174763;
    return p[35:19];
  endfunction

endpackage

>>> src/asw_front.sv
// Front end: pairs X and Y reports and classifies each event as a request.
// Depends on asw_pkg.
module asw_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           mode,
  input  logic signed [15:0]   value,
  input  logic                 screen_off,
  input  logic                 hold,
  input  logic                 full,
  output logic                 push,
  output asw_pkg::req_t        req
);
  import asw_pkg::*;

  coord_t last_x, last_x_next;
  coord_t last_y, last_y_next;
  logic   x_seen, x_seen_next;
  logic   y_seen, y_seen_next;
  coord_t coord;

  assign coord    = coord_t'(value);
  assign in_ready = !full && !hold;
  assign push     = in_valid && in_ready;

  always_comb begin
    last_x_next = last_x;
    last_y_next = last_y;
    x_seen_next = x_seen;
    y_seen_next = y_seen;
    req.op      = OP_NONE;
    if (!screen_off) begin
      if (mode == KIND_SLOT || (mode == KIND_TRACK && value == TRACK_LIFT) ||
          (mode == KIND_KEY && value == KEY_UP)) begin
        req.op = OP_RESET;
      end else begin
        if (mode == KIND_X) begin
          last_x_next = coord;
          x_seen_next = 1'b1;
        end else if (mode == KIND_Y) begin
          last_y_next = coord;
          y_seen_next = 1'b1;
        end
        if (x_seen_next && y_seen_next) begin
          x_seen_next = 1'b0;
          y_seen_next = 1'b0;
          req.op      = OP_EVAL;
        end
      end
    end
    req.x = last_x_next;
    req.y = last_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
      x_seen <= 1'b0;
      y_seen <= 1'b0;
    end else if (push) begin
      last_x <= last_x_next;
      last_y <= last_y_next;
      x_seen <= x_seen_next;
      y_seen <= y_seen_next;
    end
  end

endmodule

>>> src/asw_fifo.sv
// Short request queue between front and back end.
// Depends on asw_pkg.
module asw_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  asw_pkg::req_t wdata,
  input  logic          pop,
  output asw_pkg::req_t rdata,
  output logic          full,
  output logic          empty
);
  import asw_pkg::*;

  req_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/asw_back.sv
// Back end: zone compares, squared distance, annulus test and stroke state.
// Depends on asw_pkg.
module asw_back (
  input  logic          clk,
  input  logic          rst,
  input  asw_pkg::cfg_t cfg,
  input  logic          empty,
  input  asw_pkg::req_t rdata,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          wake_pulse
);
  import asw_pkg::*;

  typedef struct packed {
    op_t    op;
    coord_t x;
    coord_t y;
    logic   y_ok;
    logic   is_left;
    logic   is_right;
    logic   is_band;
    logic   is_low;
    logic   far;
  } pt_t;

  function automatic wide_t uw(input logic [15:0] v);
    return wide_t'(v);
  endfunction

  // settings derived from cfg and registered
  logic [14:0] t_c3, t_5c3, t_5c6, t_7c6;
  logic [29:0] ri_sq, ro_sq;
  logic [16:0] c5, c7;
  logic [16:0] q_c, q_5c, q_7c;

  assign c5   = {3'b0, cfg.center_x} * 17'd5;
  assign c7   = {3'b0, cfg.center_x} * 17'd7;
  assign q_c  = div3({3'b0, cfg.center_x});
  assign q_5c = div3(c5);
  assign q_7c = div3(c7);

  always_ff @(posedge clk) begin
    t_c3  <= q_c[14:0];
    t_5c3 <= q_5c[14:0];
    t_5c6 <= q_5c[15:1];
    t_7c6 <= q_7c[15:1];
    ri_sq <= {15'b0, cfg.inner_radius} * {15'b0, cfg.inner_radius};
    ro_sq <= {15'b0, cfg.outer_radius} * {15'b0, cfg.outer_radius};
  end

  logic advance;
  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  // stage 1: compares and distance magnitudes
  wide_t xw, yw, dx, dy, adx, ady;
  pt_t   s1_c;

  assign xw  = wide_t'(rdata.x);
  assign yw  = wide_t'(rdata.y);
  assign dx  = xw - uw({2'b0, cfg.center_x});
  assign dy  = yw - uw({1'b0, cfg.screen_height});
  assign adx = dx[WIDE_W-1] ? -dx : dx;
  assign ady = dy[WIDE_W-1] ? -dy : dy;

  always_comb begin
    s1_c.op       = rdata.op;
    s1_c.x        = rdata.x;
    s1_c.y        = rdata.y;
    s1_c.y_ok     = yw < uw({1'b0, cfg.screen_height});
    s1_c.is_left  = xw < uw({1'b0, t_c3});
    s1_c.is_right = xw > uw({1'b0, t_5c3});
    s1_c.is_band  = (xw > uw({1'b0, t_5c6})) && (xw < uw({1'b0, t_7c6}));
    s1_c.is_low   = yw > uw({1'b0, cfg.side_row});
    // a leg of 2^15 or more already lies beyond any outer radius
    s1_c.far      = (|adx[WIDE_W-1:15]) || (|ady[WIDE_W-1:15]);
  end

  logic        s1_valid, s2_valid, s3_valid;
  pt_t         s1, s2, s3;
  logic [14:0] s1_ax, s1_ay;
  logic [29:0] s2_sx, s2_sy;
  logic [30:0] d2;
  logic        s3_ring;

  assign d2 = {1'b0, s2_sx} + {1'b0, s2_sy};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !empty;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1      <= s1_c;
      s1_ax   <= adx[14:0];
      s1_ay   <= ady[14:0];
      s2      <= s1;
      s2_sx   <= {15'b0, s1_ax} * {15'b0, s1_ax};
      s2_sy   <= {15'b0, s1_ay} * {15'b0, s1_ay};
      s3      <= s2;
      s3_ring <= !s2.far && (d2 > {1'b0, ri_sq}) && (d2 < {1'b0, ro_sq});
    end
  end

  // stroke state
  logic   start_valid, start_valid_next;
  coord_t start_x, start_x_next;
  coord_t start_y, start_y_next;
  logic   armed, armed_next;
  logic   centre_passed, centre_passed_next;
  logic   pulse;
  logic   st_left, st_right, cp, at_end, arc_mode;

  always_comb begin
    if (start_valid) begin
      st_left  = (wide_t'(start_x) < uw({1'b0, t_c3})) &&
                 (wide_t'(start_y) > uw({1'b0, cfg.side_row}));
      st_right = (wide_t'(start_x) > uw({1'b0, t_5c3})) &&
                 (wide_t'(start_y) > uw({1'b0, cfg.side_row}));
    end else begin
      // start is latched from this very point
      st_left  = s3.is_left && s3.is_low;
      st_right = s3.is_right && s3.is_low;
    end
  end

  assign arc_mode = (cfg.enable_mode == MODE_ARC_CP) || (cfg.enable_mode == MODE_ARC);
  assign cp       = centre_passed || (cfg.enable_mode == MODE_ARC_CP && s3.is_band);
  assign at_end   = (st_left ? s3.is_right : s3.is_left) && s3.is_low;

  always_comb begin
    start_valid_next   = start_valid;
    start_x_next       = start_x;
    start_y_next       = start_y;
    armed_next         = armed;
    centre_passed_next = centre_passed;
    pulse              = 1'b0;
    case (s3.op)
      OP_RESET: begin
        start_valid_next   = 1'b0;
        start_x_next       = '1;
        start_y_next       = '1;
        armed_next         = 1'b1;
        centre_passed_next = 1'b0;
      end
      OP_EVAL: begin
        if (s3.y_ok && cfg.enable_mode != MODE_OFF) begin
          start_valid_next = 1'b1;
          if (!start_valid) begin
            start_x_next = s3.x;
            start_y_next = s3.y;
          end
          if (arc_mode && (st_left || st_right)) begin
            if (!s3_ring) begin
              start_valid_next   = 1'b0;
              start_x_next       = '1;
              start_y_next       = '1;
              armed_next         = 1'b1;
              centre_passed_next = 1'b0;
            end else begin
              centre_passed_next = cp;
              if (at_end && armed && (cfg.enable_mode == MODE_ARC || cp)) begin
                armed_next = 1'b0;
                pulse      = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      start_valid   <= 1'b0;
      start_x       <= '1;
      start_y       <= '1;
      armed         <= 1'b1;
      centre_passed <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid;
      if (s3_valid) begin
        start_valid   <= start_valid_next;
        start_x       <= start_x_next;
        start_y       <= start_y_next;
        armed         <= armed_next;
        centre_passed <= centre_passed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wake_pulse <= pulse;
    end
  end

endmodule

>>> src/arc_swipe_wake_detector.sv
// Arc swipe wake detector, top level: settings registers, front, queue, back.
// Events pass the queue, stages s1 to s3 and output register; throughput is one
// event per cycle when not held off, and the back end is a 3-stage pipeline plus
// output register and the 4-entry queue absorbs output stalls.
// Input is held off in a cycle with a settings write. Synchronous reset
// restores default settings and clears queue, pipeline and stroke state.
module arc_swipe_wake_detector (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  logic signed [15:0]  value,
  input  logic                screen_off,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                wake_pulse,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import asw_pkg::*;

  cfg_t cfg;
  req_t push_req, head_req;
  logic push, pop, full, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mode   <= MODE_ARC_CP;
      cfg.center_x      <= 14'd540;
      cfg.screen_height <= 15'd1920;
      cfg.inner_radius  <= 15'd390;
      cfg.outer_radius  <= 15'd630;
      cfg.side_row      <= 15'd1595;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:   cfg.enable_mode   <= cfg_data[1:0];
        REG_CENTER_X: cfg.center_x      <= cfg_data[13:0];
        REG_HEIGHT:   cfg.screen_height <= cfg_data[14:0];
        REG_INNER:    cfg.inner_radius  <= cfg_data[14:0];
        REG_OUTER:    cfg.outer_radius  <= cfg_data[14:0];
        REG_SIDE_ROW: cfg.side_row      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  asw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .value      (value),
    .screen_off (screen_off),
    .hold       (cfg_valid),
    .full       (full),
    .push       (push),
    .req        (push_req)
  );

  asw_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_req),
    .pop   (pop),
    .rdata (head_req),
    .full  (full),
    .empty (empty)
  );

  asw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .empty      (empty),
    .rdata      (head_req),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .wake_pulse (wake_pulse)
  );

endmodule

>>> src/asw_checker.sv
// Port checker for the arc swipe wake detector, bound to the top level.
// Depends on arc_swipe_wake_detector_macros.svh.
`include "arc_swipe_wake_detector_macros.svh"

module asw_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic wake_pulse,
  input logic cfg_valid
);

  `ASW_ASSERT_NR(a_reset_clears_out, clk, rst |=> !out_valid, "result shown after reset")
  `ASW_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(wake_pulse), "stalled result changed")
  `ASW_ASSERT(a_cfg_blocks_in, clk, rst, cfg_valid |-> !in_ready, "request taken during settings write")
  `ASW_ASSERT(a_single_pulse, clk, rst, out_valid && out_ready && wake_pulse |=> !(out_valid && wake_pulse), "two wake pulses in a row")

endmodule

bind arc_swipe_wake_detector asw_checker u_asw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .wake_pulse (wake_pulse),
  .cfg_valid  (cfg_valid)
);
